// ----- rtl/core/fpalu_pkg.sv -----
// Package for the Q24.8 fixed-point ALU: operation codes, request and
// result payload types, default fraction width. No dependencies.
package fpalu_pkg;

  localparam int unsigned FracBitsDefault = 8;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_INC = 4'd4, OP_DEC = 4'd5, OP_EQ = 4'd6, OP_NE = 4'd7,
    OP_GT = 4'd8, OP_GE = 4'd9, OP_LT = 4'd10, OP_LE = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_e;

  typedef struct packed {
    logic [3:0] mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic compare_true;
    logic divide_by_zero;
  } rsp_t;

endpackage

// ----- rtl/core/fixed_point_q24_8_alu.sv -----
// Q24.8 fixed-point ALU top level: decode, multiply and divide pipelines.
// Depends on fpalu_pkg and fpalu_div.
//
// Every request passes through the input register, the divider stages and
// the output register; the divider resolves one quotient bit per stage.
// All operations run through the same pipeline, so results leave in request
// order, one per cycle. busy is never raised: start is taken every cycle
// and the receiver must take each result on the cycle done_o is high.
module fixed_point_q24_8_alu #(
  parameter int unsigned FRAC_BITS = fpalu_pkg::FracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  fpalu_pkg::req_t  req_i,
  output logic             done_o,
  output fpalu_pkg::rsp_t  rsp_o
);

  localparam int unsigned NumW = 32 + FRAC_BITS;
  localparam int unsigned Lat  = NumW;   // divider stages

  assign busy = 1'b0;

  // Stage 1: register request and form magnitudes.
  logic              v1_q;
  fpalu_pkg::op_e    op1_q;
  logic signed [31:0] a1_q, b1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    op1_q <= fpalu_pkg::op_e'(req_i.mode);
    a1_q  <= req_i.operand_a;
    b1_q  <= req_i.operand_b;
  end

  logic [31:0] amag, bmag;
  assign amag = a1_q[31] ? (~a1_q + 1'b1) : a1_q;
  assign bmag = b1_q[31] ? (~b1_q + 1'b1) : b1_q;

  // Simple ops resolved in stage 1.
  logic [31:0] simple_res;
  logic        simple_cmp, simple_dz, lt, eq;
  assign lt = a1_q < b1_q;
  assign eq = a1_q == b1_q;
  always_comb begin
    simple_res = '0;
    simple_cmp = 1'b0;
    simple_dz  = 1'b0;
    case (op1_q)
      fpalu_pkg::OP_ADD:      simple_res = a1_q + b1_q;
      fpalu_pkg::OP_SUB:      simple_res = a1_q - b1_q;
      fpalu_pkg::OP_INC:      simple_res = a1_q + 32'sd1;
      fpalu_pkg::OP_DEC:      simple_res = a1_q - 32'sd1;
      fpalu_pkg::OP_EQ:       simple_cmp = eq;
      fpalu_pkg::OP_NE:       simple_cmp = !eq;
      fpalu_pkg::OP_GT:       simple_cmp = !lt && !eq;
      fpalu_pkg::OP_GE:       simple_cmp = !lt;
      fpalu_pkg::OP_LT:       simple_cmp = lt;
      fpalu_pkg::OP_LE:       simple_cmp = lt || eq;
      fpalu_pkg::OP_MIN:      simple_res = lt ? a1_q : b1_q;
      fpalu_pkg::OP_MAX:      simple_res = (!lt && !eq) ? a1_q : b1_q;
      fpalu_pkg::OP_FROM_INT: simple_res = a1_q <<< FRAC_BITS;
      fpalu_pkg::OP_TO_INT:   simple_res = a1_q >>> FRAC_BITS;
      fpalu_pkg::OP_DIV:      simple_dz  = (b1_q == '0);
      default:                simple_res = '0;
    endcase
  end

  // Divider path; a zero divisor is fed as one and its result discarded.
  logic            dv_v;
  logic [NumW-1:0] dv_q;
  fpalu_div #(.NumW(NumW), .DenW(fpalu_pkg::DataWidth)) u_div (
    .clk_i, .rst_ni,
    .valid_i (v1_q),
    .num_i   ({amag, {FRAC_BITS{1'b0}}}),
    .den_i   ((b1_q == '0) ? 32'd1 : bmag),
    .neg_i   (a1_q[31] ^ b1_q[31]),
    .valid_o (dv_v),
    .quo_o   (dv_q)
  );

  // Multiply path: magnitude product, then delay line to match.
  logic [63:0] prod_q;
  logic        mneg_q;
  always_ff @(posedge clk_i) begin
    prod_q <= amag * bmag;
    mneg_q <= a1_q[31] ^ b1_q[31];
  end
  logic [31:0] msh;
  logic [31:0] mul_res;
  assign msh     = prod_q[FRAC_BITS +: 32];
  assign mul_res = mneg_q ? (~msh + 1'b1) : msh;

  // Delay line carrying side results alongside the divider.
  typedef struct packed {
    fpalu_pkg::op_e op;
    logic [31:0]    res;
    logic           cmp;
    logic           dz;
  } side_t;
  side_t side_q [Lat];
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{op: op1_q, res: simple_res, cmp: simple_cmp, dz: simple_dz};
    side_q[1] <= '{op: side_q[0].op,
                   res: (side_q[0].op == fpalu_pkg::OP_MUL) ? mul_res : side_q[0].res,
                   cmp: side_q[0].cmp, dz: side_q[0].dz};
    for (int i = 2; i < Lat; i++) side_q[i] <= side_q[i-1];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= dv_v;
  end
  always_ff @(posedge clk_i) begin
    rsp_o.compare_true   <= side_q[Lat-1].cmp;
    rsp_o.divide_by_zero <= side_q[Lat-1].dz;
    if (side_q[Lat-1].op == fpalu_pkg::OP_DIV && !side_q[Lat-1].dz)
      rsp_o.result_value <= dv_q[31:0];
    else
      rsp_o.result_value <= side_q[Lat-1].res;
  end

endmodule

// ----- rtl/core/fpalu_div.sv -----
// Pipelined signed divider for the ALU: one restoring quotient bit per stage.
// Depends on fpalu_pkg only through the caller; stand-alone otherwise.
module fpalu_div #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [NumW-1:0]        num_i,   // magnitude of dividend
  input  logic [DenW-1:0]        den_i,   // magnitude of divisor, nonzero
  input  logic                   neg_i,   // quotient sign
  output logic                   valid_o,
  output logic [NumW-1:0]        quo_o    // signed quotient, truncated to zero
);

  // Stage s registers hold the state after quotient bit s.
  logic                  vld_q [NumW];
  logic [NumW-1:0]       num_q [NumW];
  logic [DenW-1:0]       rem_q [NumW];
  logic [DenW-1:0]       den_q [NumW];
  logic                  neg_q [NumW];

  // One quotient bit per stage, MSB first; quotient bits shift into num.
  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic            vld_in;
    logic [NumW-1:0] num_in;
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic            neg_in;
    logic [DenW:0]   trial;
    logic [DenW+1:0] diff;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    assign trial = {rem_in, num_in[NumW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    // remainder stays below the divisor, so it fits in DenW bits
    always_ff @(posedge clk_i) begin
      rem_q[s] <= diff[DenW+1] ? trial[DenW-1:0] : diff[DenW-1:0];
      num_q[s] <= {num_in[NumW-2:0], ~diff[DenW+1]};
      den_q[s] <= den_in;
      neg_q[s] <= neg_in;
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quo_o   = neg_q[NumW-1] ? (~num_q[NumW-1] + 1'b1) : num_q[NumW-1];

endmodule

// ----- rtl/core/fpalu_chk.sv -----
// Port-level checker for the fixed-point ALU, with its bind.
// Depends on fpalu_pkg.
module fpalu_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            busy,
  input logic            done_o,
  input fpalu_pkg::rsp_t rsp_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.compare_true && rsp_o.divide_by_zero))
    else $error("compare and divide-by-zero both set");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.divide_by_zero) |-> rsp_o.result_value == '0)
    else $error("nonzero result on divide by zero");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.compare_true) |-> rsp_o.result_value == '0)
    else $error("nonzero result on comparison");

  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rst_ni) |=> !done_o)
    else $error("result right after reset");

endmodule

bind fixed_point_q24_8_alu fpalu_chk u_chk (.*);
